>>> rtl/hbim_pkg.sv
// hbim_pkg: shared types and constants of the heartbeat interlock motor drive
// holds the item structs, operation and command codes and fixed-point constants
// no dependencies
package hbim_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [1:0] OP_DRIVE     = 2'd1;
    localparam logic [1:0] OP_ESTOP     = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    // drive command codes
    localparam logic [3:0] CMD_FORWARD = 4'd0;
    localparam logic [3:0] CMD_BACK    = 4'd1;
    localparam logic [3:0] CMD_LEFT    = 4'd2;
    localparam logic [3:0] CMD_RIGHT   = 4'd3;
    localparam logic [3:0] CMD_ARM     = 4'd4;
    localparam logic [3:0] CMD_NEUTRAL = 4'd5;
    localparam logic [3:0] CMD_STOP    = 4'd6;
    localparam logic [3:0] CMD_ESTOP   = 4'd7;

    // configuration register indexes
    localparam logic [1:0] REG_UNLOCK_COUNT      = 2'd0;
    localparam logic [1:0] REG_HEARTBEAT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_CHECK_PERIOD      = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [7:0]  RST_UNLOCK_COUNT      = 8'd3;
    localparam logic [15:0] RST_HEARTBEAT_TIMEOUT = 16'd500;
    localparam logic [7:0]  RST_CHECK_PERIOD      = 8'd50;

    // speed: magnitude clamp, duty = floor(mag * 1023 / 10000) as (mag * M) >> 27
    localparam logic [13:0] SPEED_FULL     = 14'd10000;
    localparam logic [23:0] DUTY_RECIP     = 24'd13730474;
    localparam int          DUTY_SHIFT     = 27;

    // angle: clamp to 0..18000, pulse = 500 + floor(a / 9), a / 9 as (a * M) >> 18
    localparam logic [14:0] ANGLE_FULL     = 15'd18000;
    localparam logic [14:0] NINTH_RECIP    = 15'd29128;
    localparam int          NINTH_SHIFT    = 18;
    localparam logic [11:0] PULSE_MIN_US   = 12'd500;
    localparam logic [11:0] NEUTRAL_PULSE  = 12'd1500;

    // servo: duty = floor(pulse * 16384 / 20000) = floor(pulse * 512 / 625)
    localparam logic [20:0] SERVO_RECIP    = 21'd1717987;
    localparam int          SERVO_SHIFT    = 21;

    // input item
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         command;
        logic signed [15:0] param_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        left_in1;
        logic        left_in2;
        logic [9:0]  left_duty;
        logic        right_in1;
        logic        right_in2;
        logic [9:0]  right_duty;
        logic        bridge_enable;
        logic [13:0] arm_duty;
        logic        locked;
        logic        stop_fired;
    } t_out_item;

    // conditioned item held in the input register
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  command;
        logic        fwd_pos;    // +param drives forward
        logic        fwd_neg;    // -param drives forward
        logic [9:0]  wheel_duty; // duty of the clamped speed magnitude
        logic [11:0] arm_pulse;  // servo pulse in us
    } t_prep;

    // configuration register set
    typedef struct packed {
        logic [7:0]  unlock_count;
        logic [15:0] beat_timeout;
        logic [7:0]  check_period_ms;
    } t_cfg;

endpackage

>>> rtl/hbim_prep.sv
// hbim_prep: conditions an incoming item before the input register
// clamps speed and angle, computes wheel duty and servo pulse; uses hbim_pkg
module hbim_prep (
    input  hbim_pkg::t_in_item i_item,
    output hbim_pkg::t_prep    o_prep
);
    import hbim_pkg::*;

    logic        neg;
    logic [16:0] abs_p;
    logic [13:0] mag;
    logic [37:0] duty_prod;
    logic [14:0] angle;
    logic [29:0] ninth_prod;
    logic [10:0] ninth;

    // speed magnitude, clamped to full scale
    always_comb begin
        neg   = i_item.param_value[15];
        abs_p = neg ? (17'd0 - {i_item.param_value[15], i_item.param_value})
                    : {1'b0, i_item.param_value};
        mag   = (abs_p > {3'b000, SPEED_FULL}) ? SPEED_FULL : abs_p[13:0];
    end

    // duty by reciprocal multiply
    assign duty_prod = {24'd0, mag} * {14'd0, DUTY_RECIP};

    // angle clamped to 0..18000, then divided by nine
    always_comb begin
        if (neg) begin
            angle = '0;
        end else if (i_item.param_value > $signed({1'b0, ANGLE_FULL})) begin
            angle = ANGLE_FULL;
        end else begin
            angle = i_item.param_value[14:0];
        end
    end

    assign ninth_prod = {15'd0, angle} * {15'd0, NINTH_RECIP};
    assign ninth      = ninth_prod[NINTH_SHIFT +: 11];

    // pack the conditioned item
    always_comb begin
        o_prep.op         = i_item.op;
        o_prep.command    = i_item.command;
        o_prep.fwd_pos    = !neg;
        o_prep.fwd_neg    = neg || (i_item.param_value == 16'sd0);
        o_prep.wheel_duty = duty_prod[DUTY_SHIFT +: 10];
        o_prep.arm_pulse  = (i_item.command == CMD_NEUTRAL) ? NEUTRAL_PULSE
                                                            : PULSE_MIN_US + {1'b0, ninth};
    end

endmodule

>>> rtl/hbim_ctrl.sv
// hbim_ctrl: interlock state, drive outputs and result register
// applies one conditioned item per advance; uses hbim_pkg
module hbim_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  hbim_pkg::t_prep    i_prep,
    input  hbim_pkg::t_cfg     i_cfg,
    output hbim_pkg::t_out_item o_result
);
    import hbim_pkg::*;

    // interlock state
    logic        r_lock,     n_lock;
    logic [7:0]  r_rcount,   n_rcount;
    logic [15:0] r_since,    n_since;
    logic [7:0]  r_phase,    n_phase;
    logic [3:0]  r_pins,     n_pins;
    logic [9:0]  r_lduty,    n_lduty;
    logic [9:0]  r_rduty,    n_rduty;
    logic [13:0] r_servo,    n_servo;
    logic        r_standby,  n_standby;
    logic        n_fired;
    t_out_item   r_result,   n_result;

    logic [32:0] servo_prod;
    logic [13:0] servo_duty;
    logic [7:0]  rcount_inc;
    logic [15:0] since_inc;
    logic [8:0]  phase_inc;
    logic        left_fwd, right_fwd;
    logic        do_estop;

    // servo duty from the pulse width
    assign servo_prod = {21'd0, i_prep.arm_pulse} * {12'd0, SERVO_RECIP};
    assign servo_duty = {2'b00, servo_prod[SERVO_SHIFT +: 12]};

    assign rcount_inc = (r_rcount == 8'hFF) ? r_rcount : r_rcount + 8'd1;
    assign since_inc  = (r_since == 16'hFFFF) ? r_since : r_since + 16'd1;
    assign phase_inc  = {1'b0, r_phase} + 9'd1;

    // wheel directions per drive command
    always_comb begin
        unique case (i_prep.command)
            CMD_FORWARD: begin left_fwd = i_prep.fwd_pos; right_fwd = i_prep.fwd_pos; end
            CMD_BACK:    begin left_fwd = i_prep.fwd_neg; right_fwd = i_prep.fwd_neg; end
            CMD_LEFT:    begin left_fwd = i_prep.fwd_neg; right_fwd = i_prep.fwd_pos; end
            CMD_RIGHT:   begin left_fwd = i_prep.fwd_pos; right_fwd = i_prep.fwd_neg; end
            default:     begin left_fwd = 1'b1;           right_fwd = 1'b1;           end
        endcase
    end

    // next state for one item
    always_comb begin
        n_lock    = r_lock;
        n_rcount  = r_rcount;
        n_since   = r_since;
        n_phase   = r_phase;
        n_pins    = r_pins;
        n_lduty   = r_lduty;
        n_rduty   = r_rduty;
        n_servo   = r_servo;
        n_standby = r_standby;
        do_estop  = 1'b0;

        unique case (i_prep.op)
            OP_HEARTBEAT: begin
                n_since = '0;
                if (r_lock) begin
                    n_rcount = rcount_inc;
                    if (rcount_inc >= i_cfg.unlock_count) begin
                        n_lock    = 1'b0;
                        n_standby = 1'b1;
                    end
                end
            end
            OP_DRIVE: begin
                if (!r_lock) begin
                    unique case (i_prep.command)
                        CMD_FORWARD, CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
                            n_lduty = i_prep.wheel_duty;
                            n_rduty = i_prep.wheel_duty;
                            n_pins  = {!right_fwd, right_fwd, !left_fwd, left_fwd};
                        end
                        CMD_ARM, CMD_NEUTRAL: begin
                            n_servo = servo_duty;
                        end
                        CMD_STOP: begin
                            n_lduty = '0;
                            n_rduty = '0;
                            n_pins  = 4'b0101;
                        end
                        CMD_ESTOP: begin
                            do_estop = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_ESTOP: begin
                do_estop = 1'b1;
            end
            OP_TICK: begin
                n_since = since_inc;
                if (phase_inc >= {1'b0, i_cfg.check_period_ms}) begin
                    n_phase = '0;
                    if (!r_lock && (since_inc > i_cfg.beat_timeout)) begin
                        do_estop = 1'b1;
                    end
                end else begin
                    n_phase = phase_inc[7:0];
                end
            end
            default: begin
            end
        endcase

        // short brake and lock
        if (do_estop) begin
            n_pins    = 4'hF;
            n_lduty   = '0;
            n_rduty   = '0;
            n_standby = 1'b0;
            n_lock    = 1'b1;
            n_rcount  = '0;
        end
        n_fired = do_estop;
    end

    // result item after the update
    always_comb begin
        n_result.left_in1      = n_pins[0];
        n_result.left_in2      = n_pins[1];
        n_result.left_duty     = n_lduty;
        n_result.right_in1     = n_pins[2];
        n_result.right_in2     = n_pins[3];
        n_result.right_duty    = n_rduty;
        n_result.bridge_enable = n_standby;
        n_result.arm_duty      = n_servo;
        n_result.locked        = n_lock;
        n_result.stop_fired    = n_fired;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock    <= 1'b1;
            r_rcount  <= '0;
            r_since   <= '0;
            r_phase   <= '0;
            r_pins    <= '0;
            r_lduty   <= '0;
            r_rduty   <= '0;
            r_servo   <= '0;
            r_standby <= 1'b0;
        end else if (i_advance) begin
            r_lock    <= n_lock;
            r_rcount  <= n_rcount;
            r_since   <= n_since;
            r_phase   <= n_phase;
            r_pins    <= n_pins;
            r_lduty   <= n_lduty;
            r_rduty   <= n_rduty;
            r_servo   <= n_servo;
            r_standby <= n_standby;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

>>> rtl/heartbeat_interlock_motor_drive_unit.sv
// heartbeat_interlock_motor_drive_unit: top level of the heartbeat interlock drive
// holds configuration registers, input register and handshake; uses hbim_pkg,
// hbim_prep and hbim_ctrl
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries heartbeat,
//   drive command, emergency stop and one-millisecond tick items. Each item
//   gives exactly one result on the output channel (o_out_valid / i_out_ready /
//   o_out_item) showing bridge pins, wheel duties, standby, servo duty, lock
//   and whether this item fired an emergency stop.
//   Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data while
//   no item is in flight: 0 recovery threshold, 1 heartbeat timeout in ms,
//   2 check period in ticks; other indexes are ignored.
//   An accepted item waits in the input register (speed clamp, wheel duty and
//   servo pulse worked out on the way in), then passes through the interlock
//   update into the result register. Throughput is one item per cycle while
//   the receiver takes each result; the two registers form a two-stage
//   pipeline that keeps accepting while the output is taken.
//   When the receiver stalls, the result holds and the input register fills,
//   then o_in_ready drops until the result is taken.
//   Synchronous reset leaves the drive locked, standby low, all pins and
//   duties zero and the configuration at 3 / 500 / 50.
module heartbeat_interlock_motor_drive_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  hbim_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output hbim_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_we,
    input  logic [hbim_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [hbim_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hbim_pkg::*;

    t_cfg   r_cfg;
    t_prep  prep;
    t_prep  r_in;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   advance;
    logic   in_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_count    <= RST_UNLOCK_COUNT;
            r_cfg.beat_timeout    <= RST_HEARTBEAT_TIMEOUT;
            r_cfg.check_period_ms <= RST_CHECK_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_UNLOCK_COUNT:      r_cfg.unlock_count    <= i_cfg_data[7:0];
                REG_HEARTBEAT_TIMEOUT: r_cfg.beat_timeout    <= i_cfg_data;
                REG_CHECK_PERIOD:      r_cfg.check_period_ms <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // item conditioning ahead of the input register
    hbim_prep u_prep (
        .i_item (i_in_item),
        .o_prep (prep)
    );

    // pipeline handshake
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= prep;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // interlock state and result register
    hbim_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_prep    (r_in),
        .i_cfg     (r_cfg),
        .o_result  (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for heartbeat_interlock_motor_drive_unit
// drives items over valid/ready, predicts each result or takes it from a table, reports mismatches field by field
// depends on hbim_pkg and the rtl top level only
module testbench;
    import hbim_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 20;

    // drive arithmetic
    localparam int SPEED_MAX      = 10000;
    localparam int DUTY_MAX       = 1023;
    localparam int ANGLE_MAX      = 18000;
    localparam int PULSE_BASE     = 500;
    localparam int PULSE_RANGE    = 2000;
    localparam int SERVO_COUNTS   = 16384;
    localparam int SERVO_FRAME_US = 20000;
    localparam int NEUTRAL_US     = 1500;
    localparam int ELAPSED_MAX    = 65535;
    localparam int COUNT_MAX      = 255;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted interlock state and register copies
    logic [7:0]  thr_reg;
    logic [15:0] tmo_reg;
    logic [7:0]  per_reg;
    bit          lk;
    int          recov;
    int          elapsed;
    int          phase_cnt;
    bit [3:0]    pins;
    int          wheel [2];
    int          arm;
    bit          standby;

    t_out_item pending_outputs[$];
    t_dir_row  dir_rows[$];
    t_out_item want_now;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    bit hold_started;
    int hold_left;

    int error_count;
    int items_sent;
    int results_checked;
    int stops_seen;
    int settings_run;

    heartbeat_interlock_motor_drive_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // clock
    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // clamp a speed, set direction pins and duty of one wheel
    task automatic set_wheel_duty(input int side, input int speed);
        int s;
        bit fwd;
        s = speed;
        if (s > SPEED_MAX) s = SPEED_MAX;
        if (s < -SPEED_MAX) s = -SPEED_MAX;
        fwd = (s >= 0);
        wheel[side] = (fwd ? s : -s) * DUTY_MAX / SPEED_MAX;
        pins[side*2 +: 2] = fwd ? 2'b01 : 2'b10;
    endtask

    task automatic set_arm_pulse(input int pulse);
        arm = (pulse * SERVO_COUNTS / SERVO_FRAME_US) & 16'h3FFF;
    endtask

    // short brake, standby low, lock
    task automatic apply_brake();
        pins     = 4'hF;
        wheel[0] = 0;
        wheel[1] = 0;
        standby  = 1'b0;
        lk       = 1'b1;
        recov    = 0;
    endtask

    // advance the predicted state by one item and return the outputs after it
    task automatic predict_drive_outputs(input t_in_item it, output t_out_item res);
        int p;
        int a;
        bit fired;
        p = int'(it.param_value);
        fired = 1'b0;
        case (it.op)
            OP_HEARTBEAT: begin
                elapsed = 0;
                if (lk) begin
                    if (recov < COUNT_MAX) recov++;
                    if (recov >= thr_reg) begin
                        lk = 1'b0;
                        standby = 1'b1;
                    end
                end
            end
            OP_DRIVE: begin
                if (!lk) begin
                    case (it.command)
                        CMD_FORWARD: begin
                            set_wheel_duty(0, p);
                            set_wheel_duty(1, p);
                        end
                        CMD_BACK: begin
                            set_wheel_duty(0, -p);
                            set_wheel_duty(1, -p);
                        end
                        CMD_LEFT: begin
                            set_wheel_duty(0, -p);
                            set_wheel_duty(1, p);
                        end
                        CMD_RIGHT: begin
                            set_wheel_duty(0, p);
                            set_wheel_duty(1, -p);
                        end
                        CMD_ARM: begin
                            a = p;
                            if (a < 0) a = 0;
                            if (a > ANGLE_MAX) a = ANGLE_MAX;
                            set_arm_pulse(PULSE_BASE + a * PULSE_RANGE / ANGLE_MAX);
                        end
                        CMD_NEUTRAL: set_arm_pulse(NEUTRAL_US);
                        CMD_STOP: begin
                            set_wheel_duty(0, 0);
                            set_wheel_duty(1, 0);
                        end
                        CMD_ESTOP: begin
                            apply_brake();
                            fired = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_ESTOP: begin
                apply_brake();
                fired = 1'b1;
            end
            OP_TICK: begin
                if (elapsed < ELAPSED_MAX) elapsed++;
                if (phase_cnt + 1 >= per_reg) begin
                    phase_cnt = 0;
                    if (!lk && elapsed > tmo_reg) begin
                        apply_brake();
                        fired = 1'b1;
                    end
                end else begin
                    phase_cnt++;
                end
            end
        endcase
        res.left_in1      = pins[0];
        res.left_in2      = pins[1];
        res.left_duty     = 10'(wheel[0]);
        res.right_in1     = pins[2];
        res.right_in2     = pins[3];
        res.right_duty    = 10'(wheel[1]);
        res.bridge_enable = standby;
        res.arm_duty      = 14'(arm);
        res.locked        = lk;
        res.stop_fired    = fired;
    endtask

    function automatic t_out_item mk_out(bit l1, bit l2, int ld, bit r1, bit r2, int rd,
                                         bit en, int ad, bit lkd, bit fd);
        t_out_item o;
        o.left_in1      = l1;
        o.left_in2      = l2;
        o.left_duty     = 10'(ld);
        o.right_in1     = r1;
        o.right_in2     = r2;
        o.right_duty    = 10'(rd);
        o.bridge_enable = en;
        o.arm_duty      = 14'(ad);
        o.locked        = lkd;
        o.stop_fired    = fd;
        return o;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [3:0] cmd, int param, bit typed,
                                    t_out_item want);
        t_dir_row r;
        r.item.op          = op;
        r.item.command     = cmd;
        r.item.param_value = 16'(param);
        r.typed            = typed;
        r.want             = want;
        dir_rows.push_back(r);
    endfunction

    // offer one item, wait for acceptance, then queue what it should produce
    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_drive_outputs(it, res);
        pending_outputs.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic offer_op(input logic [1:0] op, input logic [3:0] cmd, input int param);
        t_in_item it;
        it.op          = op;
        it.command     = cmd;
        it.param_value = 16'(param);
        offer_item(it, 1'b0, '0);
    endtask

    // drop valid and wait until every queued result has been taken
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            REG_UNLOCK_COUNT:      thr_reg = data[7:0];
            REG_HEARTBEAT_TIMEOUT: tmo_reg = data;
            REG_CHECK_PERIOD:      per_reg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_phase(input int thr, input int tmo, input int per);
        wait_for_idle();
        write_cfg(REG_UNLOCK_COUNT, 16'(thr));
        write_cfg(REG_HEARTBEAT_TIMEOUT, 16'(tmo));
        write_cfg(REG_CHECK_PERIOD, 16'(per));
        settings_run++;
    endtask

    // parameter mix: extremes, in-range speeds and angles, raw values
    function automatic logic [15:0] pick_param();
        case ($urandom_range(8))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'(SPEED_MAX);
            5: return 16'(-SPEED_MAX);
            6: return 16'($urandom_range(2 * SPEED_MAX) - SPEED_MAX);
            7: return 16'($urandom_range(ANGLE_MAX + 1000) - 500);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly heartbeats so the drive gets unlocked, the rest drive commands, ticks and emergency stops
    function automatic t_in_item pick_item();
        t_in_item it;
        int r;
        int c;
        it.command     = 4'($urandom_range(15));
        it.param_value = pick_param();
        r = $urandom_range(99);
        if ((lk && r < 50) || r < 60) begin
            it.op = OP_HEARTBEAT;
        end else if (r < 90) begin
            it.op = OP_DRIVE;
            c = $urandom_range(99);
            if (c < 88) it.command = 4'($urandom_range(CMD_STOP));
            else if (c < 93) it.command = CMD_ESTOP;
            else it.command = 4'($urandom_range(15, CMD_ESTOP + 1));
        end else if (r < 97) begin
            it.op = OP_TICK;
        end else begin
            it.op = OP_ESTOP;
        end
        return it;
    endfunction

    // random items with occasional tick bursts long enough to time out
    task automatic run_random(input int n);
        int done;
        int burst;
        t_in_item it;
        done = 0;
        while (done < n) begin
            if ($urandom_range(99) < 8) begin
                burst = $urandom_range(40, 1);
                repeat (burst) begin
                    offer_op(OP_TICK, 4'($urandom_range(15)), int'($signed(pick_param())));
                    done++;
                end
            end else begin
                it = pick_item();
                offer_item(it, 1'b0, '0);
                done++;
            end
        end
    endtask

    task automatic report_field(input string nm, input logic [15:0] w, input logic [15:0] g);
        if (w !== g)
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, nm, w, g);
    endtask

    task automatic compare_outputs(input t_out_item want, input t_out_item got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                report_field("left_in1", 16'(want.left_in1), 16'(got.left_in1));
                report_field("left_in2", 16'(want.left_in2), 16'(got.left_in2));
                report_field("left_duty", 16'(want.left_duty), 16'(got.left_duty));
                report_field("right_in1", 16'(want.right_in1), 16'(got.right_in1));
                report_field("right_in2", 16'(want.right_in2), 16'(got.right_in2));
                report_field("right_duty", 16'(want.right_duty), 16'(got.right_duty));
                report_field("bridge_enable", 16'(want.bridge_enable),
                             16'(got.bridge_enable));
                report_field("arm_duty", 16'(want.arm_duty), 16'(got.arm_duty));
                report_field("locked", 16'(want.locked), 16'(got.locked));
                report_field("stop_fired", 16'(want.stop_fired), 16'(got.stop_fired));
            end
        end
    endtask

    // receiver ready: one long hold-off on request, otherwise random idling
    initial begin
        out_ready    = 1'b0;
        hold_started = 1'b0;
        hold_left    = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else begin
                out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (pending_outputs.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: expected none, actual %h", $time, out_item);
            end else begin
                want_now = pending_outputs.pop_front();
                compare_outputs(want_now, out_item);
                results_checked++;
                if (out_item.stop_fired === 1'b1) stops_seen++;
            end
        end
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("timeout with %0d results outstanding", pending_outputs.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        in_valid        = 1'b0;
        in_item         = '0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        send_idle_pct   = 7;
        recv_idle_pct   = 60;
        hold_req        = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        stops_seen      = 0;
        settings_run    = 1;

        thr_reg   = RST_UNLOCK_COUNT;
        tmo_reg   = RST_HEARTBEAT_TIMEOUT;
        per_reg   = RST_CHECK_PERIOD;
        lk        = 1'b1;
        recov     = 0;
        elapsed   = 0;
        phase_cnt = 0;
        pins      = '0;
        wheel[0]  = 0;
        wheel[1]  = 0;
        arm       = 0;
        standby   = 1'b0;

        // directed rows: locked drive ignored, unlock, extremes, arm, ignored codes, stops
        add_row(OP_DRIVE, CMD_FORWARD, 10000, 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(OP_HEARTBEAT, 0, 0, 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(OP_HEARTBEAT, 0, 0, 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(OP_HEARTBEAT, 15, -1, 1, mk_out(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        add_row(OP_DRIVE, CMD_FORWARD, 32767, 1, mk_out(1, 0, 1023, 1, 0, 1023, 1, 0, 0, 0));
        add_row(OP_DRIVE, CMD_BACK, -32768, 1, mk_out(1, 0, 1023, 1, 0, 1023, 1, 0, 0, 0));
        add_row(OP_DRIVE, CMD_FORWARD, -32768, 1, mk_out(0, 1, 1023, 0, 1, 1023, 1, 0, 0, 0));
        add_row(OP_DRIVE, CMD_LEFT, 5000, 0, '0);
        add_row(OP_DRIVE, CMD_RIGHT, -1, 0, '0);
        add_row(OP_DRIVE, CMD_ARM, -100, 0, '0);
        add_row(OP_DRIVE, CMD_ARM, 32767, 0, '0);
        add_row(OP_DRIVE, CMD_ARM, 9000, 0, '0);
        add_row(OP_DRIVE, CMD_NEUTRAL, 12345, 0, '0);
        add_row(OP_DRIVE, CMD_STOP, 777, 0, '0);
        add_row(OP_DRIVE, 4'd8, 5000, 0, '0);
        add_row(OP_DRIVE, 4'd15, -5000, 0, '0);
        add_row(OP_TICK, 0, 0, 0, '0);
        add_row(OP_DRIVE, CMD_ESTOP, 0, 1, mk_out(1, 1, 0, 1, 1, 0, 0, 1228, 1, 1));
        add_row(OP_ESTOP, 9, 123, 1, mk_out(1, 1, 0, 1, 1, 0, 0, 1228, 1, 1));
        add_row(OP_DRIVE, CMD_ARM, 0, 0, '0);
        add_row(OP_TICK, CMD_ESTOP, -5, 0, '0);
        add_row(OP_HEARTBEAT, 0, 0, 0, '0);
        add_row(OP_HEARTBEAT, 0, 0, 0, '0);
        add_row(OP_HEARTBEAT, 0, 0, 0, '0);
        add_row(OP_ESTOP, 0, 0, 1, mk_out(1, 1, 0, 1, 1, 0, 0, 1228, 1, 1));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // sender mostly busy, receiver often stalled
        set_phase(1, 3, 1);
        run_random(60);
        set_phase(0, 1, 0);
        run_random(40);

        // sender often idle, receiver mostly ready
        send_idle_pct = 60;
        recv_idle_pct = 7;
        set_phase(255, 65534, 255);
        repeat (256) offer_op(OP_HEARTBEAT, 4'($urandom_range(15)), int'($urandom_range(65535)));
        run_random(30);
        set_phase(2, 10, 4);
        run_random(60);

        // no idling, with one long receiver hold-off to fill the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_phase(5, 20, 3);
        hold_req = 1'b1;
        run_random(70);

        // drive runs without heartbeats until the periodic check times it out
        set_phase(1, 4, 2);
        offer_op(OP_HEARTBEAT, 0, 0);
        offer_op(OP_DRIVE, CMD_FORWARD, 5000);
        repeat (8) offer_op(OP_TICK, 0, 0);

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items over %0d register settings, %0d results checked",
                 items_sent, settings_run, results_checked);
        $display("%0d emergency stops observed, %0d mismatching results",
                 stops_seen, error_count);
        if (error_count == 0 && pending_outputs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> heartbeat_interlock_motor_drive_unit.f
rtl/hbim_pkg.sv
rtl/hbim_prep.sv
rtl/hbim_ctrl.sv
rtl/heartbeat_interlock_motor_drive_unit.sv
tb/testbench.sv
